@@ design/strb64_pkg.sv @@
// shared types, constants and the character lookup for the strict base64 decoder
package strb64_pkg;

	localparam int unsigned LIMIT_MAX = 8388608;
	localparam int unsigned TOTAL_W = 24;
	localparam logic [TOTAL_W-1:0] LIMIT_MAX_V = TOTAL_W'(LIMIT_MAX);
	localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

	localparam logic [7:0] CH_PAD = 8'h3d;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [2:0] FULL_GROUP = 3'd4;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_CHAR   = 2'd1,
		ST_OVER_LIMIT = 2'd2,
		ST_BAD_LENGTH = 2'd3
	} status_t;

	typedef struct packed {
		logic       none;
		logic [5:0] val;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] ch);
		sextet_t r;
		r.none = 1'b0;
		r.val = '0;
		if (ch >= 8'h41 && ch <= 8'h5a) begin
			r.val = 6'(ch - 8'h41);
		end else if (ch >= 8'h61 && ch <= 8'h7a) begin
			r.val = 6'(ch - 8'h61 + 8'd26);
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			r.val = 6'(ch - 8'h30 + 8'd52);
		end else if (ch == CH_PLUS) begin
			r.val = 6'd62;
		end else if (ch == CH_SLASH) begin
			r.val = 6'd63;
		end else begin
			r.none = 1'b1;
		end
		return r;
	endfunction

endpackage

@@ design/strict_base64_decoder.sv @@
// strict padded base64 decoder, one 4-character group per cycle unless stalled
//
// input channel: one request carries a four-character group, the number of
// characters present and a flag for the last group of a text; accepted when
// in_valid is high and in_stall is low
// output channel: one request per group with up to three decoded bytes, their
// count, the sticky status of the text and a copy of the last-group flag;
// taken when out_valid is high and out_stall is low
// a group is decoded and checked against the running total in the input
// register, then passes into the output register that drives out_valid
// throughput: one group per cycle while in_stall is low; the add and
// compare of the running total against the byte limit, then the add of
// the byte count, is the path
// the user writes the byte limit through cfg_wr_en / cfg_wr_data only while
// idle, the block does not enforce it; reset clears both registers, the
// running total and the status, and sets the byte limit to its largest value
// when the receiver stalls the output register holds, the input register
// keeps one more group, and in_stall rises only when both are full
module strict_base64_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_first,
	input  logic [7:0]  char_second,
	input  logic [7:0]  char_third,
	input  logic [7:0]  char_fourth,
	input  logic [2:0]  valid_chars,
	input  logic        final_group,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  byte_first,
	output logic [7:0]  byte_second,
	output logic [7:0]  byte_third,
	output logic [1:0]  byte_count,
	output logic [1:0]  status,
	output logic        final_result
);

	localparam int unsigned TW = strb64_pkg::TOTAL_W;

	logic [TW-1:0] limit_q;
	logic [TW-1:0] total_q;
	strb64_pkg::status_t sticky_q;

	logic       valid_s1;
	logic [7:0] c0_s1, c1_s1, c2_s1, c3_s1;
	logic [2:0] nchars_s1;
	logic       last_s1;

	logic       valid_s2;
	logic [7:0] b0_s2, b1_s2, b2_s2;
	logic [1:0] count_s2;
	strb64_pkg::status_t status_s2;
	logic       last_s2;

	logic out_ready;
	logic adv;

	strb64_pkg::sextet_t sa, sb, sc, sd;
	logic pad2, pad1, bad, over;
	logic [1:0] want;
	logic [TW:0] sum_want;
	logic [TW:0] sum_cnt;
	strb64_pkg::status_t grp_status, new_status;
	logic [1:0] cnt;
	logic [7:0] b0, b1, b2;
	logic [TW-1:0] new_total;

	assign out_ready = !valid_s2 || !out_stall;
	assign adv = valid_s1 && out_ready;
	assign in_stall = valid_s1 && !out_ready;

	always_comb begin
		sa = strb64_pkg::sextet_of(c0_s1);
		sb = strb64_pkg::sextet_of(c1_s1);
		sc = strb64_pkg::sextet_of(c2_s1);
		sd = strb64_pkg::sextet_of(c3_s1);
		pad2 = last_s1 && c2_s1 == strb64_pkg::CH_PAD && c3_s1 == strb64_pkg::CH_PAD;
		pad1 = last_s1 && !sc.none && c3_s1 == strb64_pkg::CH_PAD;
		bad = sa.none || sb.none || (sc.none && !pad2) || (sd.none && !pad2 && !pad1)
			|| (pad2 && sb.val[3:0] != 4'd0) || (pad1 && sc.val[1:0] != 2'd0);
		want = pad2 ? 2'd1 : (pad1 ? 2'd2 : 2'd3);
		sum_want = {1'b0, total_q} + {{(TW-1){1'b0}}, want};
		over = sum_want > {1'b0, limit_q};
		grp_status = strb64_pkg::ST_OK;
		cnt = 2'd0;
		b0 = '0;
		b1 = '0;
		b2 = '0;
		if (nchars_s1 != strb64_pkg::FULL_GROUP) begin
			grp_status = strb64_pkg::ST_BAD_LENGTH;
		end else if (over) begin
			grp_status = strb64_pkg::ST_OVER_LIMIT;
		end else if (bad) begin
			grp_status = strb64_pkg::ST_BAD_CHAR;
		end else begin
			cnt = want;
		end
		new_status = (sticky_q == strb64_pkg::ST_OK) ? grp_status : sticky_q;
		if (new_status != strb64_pkg::ST_OK) begin
			cnt = 2'd0;
		end else begin
			b0 = {sa.val, sb.val[5:4]};
			if (cnt >= 2'd2) begin
				b1 = {sb.val[3:0], sc.val[5:2]};
			end
			if (cnt == 2'd3) begin
				b2 = {sc.val[1:0], sd.val};
			end
		end
		sum_cnt = {1'b0, total_q} + {{(TW-1){1'b0}}, cnt};
		new_total = sum_cnt[TW] ? strb64_pkg::TOTAL_SAT : sum_cnt[TW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= strb64_pkg::LIMIT_MAX_V;
		end else if (cfg_wr_en) begin
			limit_q <= (cfg_wr_data < strb64_pkg::LIMIT_MAX_V) ? cfg_wr_data
				: strb64_pkg::LIMIT_MAX_V;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			c0_s1 <= char_first;
			c1_s1 <= char_second;
			c2_s1 <= char_third;
			c3_s1 <= char_fourth;
			nchars_s1 <= valid_chars;
			last_s1 <= final_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			sticky_q <= strb64_pkg::ST_OK;
		end else if (adv) begin
			if (last_s1) begin
				total_q <= '0;
				sticky_q <= strb64_pkg::ST_OK;
			end else begin
				total_q <= new_total;
				sticky_q <= new_status;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b0_s2 <= b0;
			b1_s2 <= b1;
			b2_s2 <= b2;
			count_s2 <= cnt;
			status_s2 <= new_status;
			last_s2 <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign byte_first = b0_s2;
	assign byte_second = b1_s2;
	assign byte_third = b2_s2;
	assign byte_count = count_s2;
	assign status = status_s2;
	assign final_result = last_s2;

endmodule

@@ design/strb64_checker.sv @@
// port-level checks for the strict base64 decoder and their binding
module strb64_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] byte_first,
	input logic [7:0] byte_second,
	input logic [7:0] byte_third,
	input logic [1:0] byte_count,
	input logic [1:0] status
);

	// a held output request stays valid with its first byte, count and status
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(byte_first) && $stable(status)
			&& $stable(byte_count))
		else $error("output request changed while stalled");

	// an error blanks the bytes
	a_err_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != strb64_pkg::ST_OK |->
			byte_count == 2'd0 && byte_first == 8'd0 && byte_second == 8'd0
			&& byte_third == 8'd0)
		else $error("bytes reported with an error status");

	// a good group always yields at least one byte
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == strb64_pkg::ST_OK |-> byte_count != 2'd0)
		else $error("good group with no bytes");

	// unused byte slots are zero
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == strb64_pkg::ST_OK && byte_count != 2'd3 |->
			byte_third == 8'd0 && (byte_count != 2'd1 || byte_second == 8'd0))
		else $error("unused byte slot not zero");

endmodule

bind strict_base64_decoder strb64_checker u_strb64_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.byte_first (byte_first),
	.byte_second(byte_second),
	.byte_third (byte_third),
	.byte_count (byte_count),
	.status     (status)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// testbench for strict_base64_decoder: directed and random base64 texts checked by a local decoder model
module tb_top;

	localparam int WATCH_LIMIT = 2000;
	localparam int PHASE_GROUPS = 220;
	localparam int NOISE_PCT = 25;

	typedef struct packed {
		logic [7:0]          b0;
		logic [7:0]          b1;
		logic [7:0]          b2;
		logic [1:0]          count;
		strb64_pkg::status_t stat;
		logic                last;
	} decoded_t;

	typedef struct packed {
		logic [3:0][7:0] ch;
		logic [2:0]      nv;
		logic            last;
	} group_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [23:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_first = '0;
	logic [7:0]  char_second = '0;
	logic [7:0]  char_third = '0;
	logic [7:0]  char_fourth = '0;
	logic [2:0]  valid_chars = strb64_pkg::FULL_GROUP;
	logic        final_group = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  byte_first;
	logic [7:0]  byte_second;
	logic [7:0]  byte_third;
	logic [1:0]  byte_count;
	logic [1:0]  status;
	logic        final_result;

	logic [23:0]         byte_limit_cur = strb64_pkg::LIMIT_MAX_V;
	logic [23:0]         text_total = '0;
	strb64_pkg::status_t text_status = strb64_pkg::ST_OK;
	decoded_t            decoded_due[$];

	bit in_calm = 1'b0;
	bit out_calm = 1'b0;
	int errors = 0;
	int groups_sent = 0;
	int texts_sent = 0;
	int results_seen = 0;
	int failed_texts = 0;
	int limit_writes = 0;
	int quiet = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	strict_base64_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_first   (char_first),
		.char_second  (char_second),
		.char_third   (char_third),
		.char_fourth  (char_fourth),
		.valid_chars  (valid_chars),
		.final_group  (final_group),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_first   (byte_first),
		.byte_second  (byte_second),
		.byte_third   (byte_third),
		.byte_count   (byte_count),
		.status       (status),
		.final_result (final_result)
	);

	// bit 6 set: not an alphabet character
	function automatic logic [6:0] sextet_code(input logic [7:0] ch);
		if (ch >= 8'("A") && ch <= 8'("Z")) begin
			return {1'b0, 6'(ch - 8'("A"))};
		end
		if (ch >= 8'("a") && ch <= 8'("z")) begin
			return {1'b0, 6'(ch - 8'("a") + 8'd26)};
		end
		if (ch >= 8'("0") && ch <= 8'("9")) begin
			return {1'b0, 6'(ch - 8'("0") + 8'd52)};
		end
		if (ch == strb64_pkg::CH_PLUS) begin
			return 7'd62;
		end
		if (ch == strb64_pkg::CH_SLASH) begin
			return 7'd63;
		end
		return 7'h40;
	endfunction

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		if (v < 6'd26) begin
			return 8'("A") + 8'(v);
		end
		if (v < 6'd52) begin
			return 8'("a") + 8'(v - 6'd26);
		end
		if (v < 6'd62) begin
			return 8'("0") + 8'(v - 6'd52);
		end
		return (v == 6'd62) ? strb64_pkg::CH_PLUS : strb64_pkg::CH_SLASH;
	endfunction

	function automatic decoded_t decode_group(input group_t g);
		decoded_t r;
		logic [6:0] a, b, c, d;
		logic pad1, pad2, bad;
		logic [1:0] want;
		logic [24:0] lim, sum;
		strb64_pkg::status_t grp;
		r = '0;
		grp = strb64_pkg::ST_OK;
		a = sextet_code(g.ch[0]);
		b = sextet_code(g.ch[1]);
		c = sextet_code(g.ch[2]);
		d = sextet_code(g.ch[3]);
		pad2 = g.last && g.ch[2] == strb64_pkg::CH_PAD && g.ch[3] == strb64_pkg::CH_PAD;
		pad1 = g.last && !c[6] && g.ch[3] == strb64_pkg::CH_PAD;
		if (g.nv != strb64_pkg::FULL_GROUP) begin
			grp = strb64_pkg::ST_BAD_LENGTH;
		end else begin
			bad = a[6] || b[6] || (c[6] && !pad2) || (d[6] && !pad2 && !pad1) ||
				(pad2 && b[3:0] != 4'd0) || (pad1 && c[1:0] != 2'd0);
			want = pad2 ? 2'd1 : (pad1 ? 2'd2 : 2'd3);
			lim = (byte_limit_cur < strb64_pkg::LIMIT_MAX_V) ? 25'(byte_limit_cur)
				: 25'(strb64_pkg::LIMIT_MAX_V);
			if (25'(text_total) + 25'(want) > lim) begin
				grp = strb64_pkg::ST_OVER_LIMIT;
			end else if (bad) begin
				grp = strb64_pkg::ST_BAD_CHAR;
			end else begin
				r.count = want;
				r.b0 = {a[5:0], b[5:4]};
				if (want >= 2'd2) begin
					r.b1 = {b[3:0], c[5:2]};
				end
				if (want == 2'd3) begin
					r.b2 = {c[1:0], d[5:0]};
				end
			end
		end
		if (text_status == strb64_pkg::ST_OK) begin
			text_status = grp;
		end
		if (text_status != strb64_pkg::ST_OK) begin
			r.count = '0;
			r.b0 = '0;
			r.b1 = '0;
			r.b2 = '0;
		end else begin
			sum = 25'(text_total) + 25'(r.count);
			text_total = (sum > 25'(strb64_pkg::TOTAL_SAT)) ? strb64_pkg::TOTAL_SAT : sum[23:0];
		end
		r.stat = text_status;
		r.last = g.last;
		if (g.last) begin
			text_total = '0;
			text_status = strb64_pkg::ST_OK;
		end
		return r;
	endfunction

	function automatic group_t text_group(input string s, input logic last,
		input logic [2:0] nv = strb64_pkg::FULL_GROUP);
		group_t g;
		for (int i = 0; i < 4; i++) begin
			g.ch[i] = s[i];
		end
		g.nv = nv;
		g.last = last;
		return g;
	endfunction

	function automatic group_t pick_group(input logic last, input int noise_pct);
		group_t g;
		int pos;
		g.last = last;
		g.nv = strb64_pkg::FULL_GROUP;
		for (int i = 0; i < 4; i++) begin
			g.ch[i] = sextet_char(6'($urandom_range(0, 63)));
		end
		if (last) begin
			case ($urandom_range(0, 2))
				1: begin
					g.ch[2] = sextet_char({4'($urandom_range(0, 15)), 2'b00});
					g.ch[3] = strb64_pkg::CH_PAD;
				end
				2: begin
					g.ch[1] = sextet_char({2'($urandom_range(0, 3)), 4'b0000});
					g.ch[2] = strb64_pkg::CH_PAD;
					g.ch[3] = strb64_pkg::CH_PAD;
				end
				default: begin
				end
			endcase
		end
		if ($urandom_range(1, 100) <= noise_pct) begin
			pos = $urandom_range(0, 3);
			case ($urandom_range(0, 5))
				0: begin
					for (int i = 0; i < 4; i++) begin
						g.ch[i] = 8'($urandom_range(0, 255));
					end
				end
				1: g.ch[pos] = 8'($urandom_range(0, 255));
				2: g.ch[pos] = strb64_pkg::CH_PAD;
				3: g.nv = 3'($urandom_range(1, 3));
				4: begin
					g.ch[2] = sextet_char(6'($urandom_range(0, 63)));
					g.ch[3] = strb64_pkg::CH_PAD;
				end
				default: begin
					g.ch[1] = sextet_char(6'($urandom_range(0, 63)));
					g.ch[2] = strb64_pkg::CH_PAD;
					g.ch[3] = strb64_pkg::CH_PAD;
				end
			endcase
		end
		return g;
	endfunction

	task automatic send_group(input group_t g);
		int gap;
		decoded_t exp_res;
		if ($urandom_range(0, 39) == 0) begin
			in_calm = !in_calm;
		end
		gap = in_calm ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_first <= g.ch[0];
		char_second <= g.ch[1];
		char_third <= g.ch[2];
		char_fourth <= g.ch[3];
		valid_chars <= g.nv;
		final_group <= g.last;
		do @(posedge clk); while (in_stall);
		exp_res = decode_group(g);
		decoded_due = {decoded_due, exp_res};
		groups_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (decoded_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_limit(input logic [23:0] v);
		drain_results();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		byte_limit_cur = v;
		limit_writes++;
	endtask

	task automatic send_text(input int ngroups, input int noise_pct);
		for (int i = 0; i < ngroups; i++) begin
			send_group(pick_group(i == ngroups - 1, noise_pct));
		end
		texts_sent++;
	endtask

	task automatic test_directed();
		group_t g;
		send_group(text_group("TWFu", 1'b1));
		send_group(text_group("AAAA", 1'b0));
		send_group(text_group("////", 1'b0));
		send_group(text_group("Za+/", 1'b1));
		send_group(text_group("TQ==", 1'b1));
		send_group(text_group("TWE=", 1'b1));
		// nonzero bits under the padding
		send_group(text_group("TR==", 1'b1));
		send_group(text_group("TWF=", 1'b1));
		// padding in a group that is not the last
		send_group(text_group("TQ==", 1'b0));
		send_group(text_group("AAAA", 1'b1));
		send_group(text_group("AAAA", 1'b0, 3'd1));
		send_group(text_group("AAAA", 1'b0, 3'd2));
		send_group(text_group("AAAA", 1'b1, 3'd3));
		g = text_group("AAAA", 1'b1);
		g.ch[0] = 8'h00;
		g.ch[1] = 8'hff;
		send_group(g);
		// characters just outside the upper- and lower-case letter ranges
		g = text_group("@[A{", 1'b1);
		g.ch[2] = 8'h60;
		send_group(g);
		send_group(text_group("TQ=A", 1'b1));
		send_group(text_group("=AAA", 1'b1));
		// first error of the text is kept
		send_group(text_group("A-AA", 1'b0));
		send_group(text_group("AAAA", 1'b1, 3'd2));
		texts_sent += 13;
	endtask

	task automatic test_limit_edges();
		write_limit(24'd1);
		send_group(text_group("TQ==", 1'b1));
		send_group(text_group("TWE=", 1'b1));
		send_group(text_group("TWFu", 1'b1, 3'd3));
		send_group(text_group("-WFu", 1'b1));
		write_limit(24'd6);
		send_group(text_group("AAAA", 1'b0));
		send_group(text_group("AAAA", 1'b1));
		send_group(text_group("AAAA", 1'b0));
		send_group(text_group("AAAA", 1'b0));
		send_group(text_group("AAAA", 1'b1));
		texts_sent += 6;
	endtask

	task automatic test_random();
		logic [23:0] limits[5];
		int start;
		limits[0] = strb64_pkg::LIMIT_MAX_V;
		limits[1] = 24'd1;
		limits[2] = 24'($urandom_range(2, 40));
		limits[3] = 24'($urandom_range(1, strb64_pkg::LIMIT_MAX));
		limits[4] = 24'($urandom_range(41, 200));
		foreach (limits[p]) begin
			write_limit(limits[p]);
			start = groups_sent;
			while (groups_sent - start < PHASE_GROUPS) begin
				send_text($urandom_range(1, 8), NOISE_PCT);
				if (groups_sent - start >= PHASE_GROUPS / 2 && $urandom_range(0, 9) == 0) begin
					drain_results();
				end
			end
			drain_results();
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
		if (exp !== act) begin
			$display("%0t: %s expected %0d got %0d", $time, name, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (final_result === 1'b1 && status !== 2'(strb64_pkg::ST_OK)) begin
				failed_texts++;
			end
			if (decoded_due.size() == 0) begin
				$display("%0t: result with no group pending, expected none got status %0d",
					$time, status);
				errors++;
			end else begin
				want = decoded_due.pop_front();
				check_field("byte_first", want.b0, byte_first);
				check_field("byte_second", want.b1, byte_second);
				check_field("byte_third", want.b2, byte_third);
				check_field("byte_count", 8'(want.count), 8'(byte_count));
				check_field("status", 8'(want.stat), 8'(status));
				check_field("final_result", 8'(want.last), 8'(final_result));
			end
		end
	end

	initial begin
		int w;
		forever begin
			if ($urandom_range(0, 39) == 0) begin
				out_calm = !out_calm;
			end
			w = out_calm ? 0 : $urandom_range(0, 13);
			@(negedge clk);
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= WATCH_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_limit_edges();
		test_random();
		drain_results();
		repeat (10) @(posedge clk);
		$display("%0d groups in %0d texts sent, %0d results checked", groups_sent, texts_sent,
			results_seen);
		$display("%0d texts ended with an error status, %0d byte limit writes", failed_texts,
			limit_writes);
		if (errors == 0 && decoded_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
